[hw/rtl/bgrw_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgrw_pkg
// Shared types, codes and helpers of the biased graph random walk core.
// ----------------------------------------------------------------------------
package bgrw_pkg;

	localparam int DEF_MAX_NODES = 1024;
	localparam int DEF_MAX_EDGES = 8192;
	localparam logic [5:0] MAX_WALK = 6'd63;
	localparam logic [16:0] FULL_ACCEPT = 17'd65536;
	localparam logic [7:0] TRY_LAST = 8'd255;

	localparam logic [1:0] OP_ROW  = 2'd0;
	localparam logic [1:0] OP_NBR  = 2'd1;
	localparam logic [1:0] OP_WALK = 2'd2;

	localparam logic [2:0] CFG_WALK_LENGTH   = 3'd0;
	localparam logic [2:0] CFG_RETURN_ACCEPT = 3'd1;
	localparam logic [2:0] CFG_COMMON_ACCEPT = 3'd2;
	localparam logic [2:0] CFG_FAR_ACCEPT    = 3'd3;
	localparam logic [2:0] CFG_RNG_SEED      = 3'd4;
	localparam logic [2:0] CFG_EDGE_COUNT    = 3'd5;

	typedef enum logic [1:0] {
		CMD_ROW,
		CMD_NBR,
		CMD_WALK
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [12:0] addr;
		logic [13:0] value;
		logic [9:0]  node;
	} cmd_t;

	typedef struct packed {
		logic [5:0]  step_limit;
		logic [16:0] return_accept;
		logic [16:0] common_accept;
		logic [16:0] far_accept;
		logic [13:0] edge_count;
	} cfg_t;

	function automatic logic [31:0] next_draw(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/biased_graph_random_walk_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// biased_graph_random_walk_core
// Node2vec-style biased random walk over a CSR graph held in on-chip stores.
//
// Channel  Dir  Handshake          Beat
// in       in   in_valid/in_ready  operation, table_index, table_value, start_node
// out      out  out_valid/out_ready visited_node, step_number, last_of_walk
// cfg      in   cfg_we             cfg_index, cfg_data
//
// Table writes pass through front, queue and engine.
// A walk step runs the bit-serial remainder; a biased step adds an adjacency
// scan and repeats per rejection.
// Reset leaves the graph stores undefined; the generator starts at seed 1.
// A stalled out channel holds the engine; the queue lets the front keep taking beats until it fills.
// ----------------------------------------------------------------------------
module biased_graph_random_walk_core #(
	parameter int MAX_NODES = bgrw_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = bgrw_pkg::DEF_MAX_EDGES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  operation,
	input  wire logic [12:0] table_index,
	input  wire logic [13:0] table_value,
	input  wire logic [9:0]  start_node,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [9:0]       visited_node,
	output logic [5:0]       step_number,
	output logic             last_of_walk,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import bgrw_pkg::*;

	cfg_t cfg_q;
	logic seed_load;
	logic push_valid;
	logic push_ready;
	cmd_t push_cmd;
	logic pop_valid;
	logic pop_ready;
	cmd_t pop_cmd;

	assign seed_load = cfg_we && cfg_index == CFG_RNG_SEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_limit    <= 6'd8;
			cfg_q.return_accept <= FULL_ACCEPT;
			cfg_q.common_accept <= FULL_ACCEPT;
			cfg_q.far_accept    <= FULL_ACCEPT;
			cfg_q.edge_count    <= 14'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WALK_LENGTH:   cfg_q.step_limit    <= cfg_data[5:0];
				CFG_RETURN_ACCEPT: cfg_q.return_accept <= cfg_data[16:0];
				CFG_COMMON_ACCEPT: cfg_q.common_accept <= cfg_data[16:0];
				CFG_FAR_ACCEPT:    cfg_q.far_accept    <= cfg_data[16:0];
				CFG_EDGE_COUNT:    cfg_q.edge_count    <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	bgrw_front #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_front (
		.clk, .arst_n, .in_valid, .in_ready, .operation, .table_index,
		.table_value, .start_node, .push_valid, .push_ready, .push_cmd
	);

	bgrw_queue u_queue (
		.clk, .arst_n, .push_valid, .push_ready, .push_cmd,
		.pop_valid, .pop_ready, .pop_cmd
	);

	bgrw_back #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_back (
		.clk, .arst_n, .cfg(cfg_q), .seed_load, .seed(cfg_data),
		.pop_valid, .pop_ready, .pop_cmd, .out_valid, .out_ready,
		.visited_node, .step_number, .last_of_walk
	);

endmodule
`default_nettype wire

[hw/rtl/bgrw_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgrw_front
// Input stage: takes item beats, drops null operations and out-of-range
// table writes, and hands commands to the queue.
// ----------------------------------------------------------------------------
module bgrw_front #(
	parameter int MAX_NODES = bgrw_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = bgrw_pkg::DEF_MAX_EDGES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   operation,
	input  wire logic [12:0]  table_index,
	input  wire logic [13:0]  table_value,
	input  wire logic [9:0]   start_node,
	output logic              push_valid,
	input  wire logic         push_ready,
	output bgrw_pkg::cmd_t    push_cmd
);
	import bgrw_pkg::*;

	localparam logic [31:0] ROWS32  = 32'(MAX_NODES + 1);
	localparam logic [31:0] EDGES32 = 32'(MAX_EDGES);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic        keep;
	cmd_t        cmd_in;
	logic [31:0] idx32;

	assign idx32 = 32'(table_index);

	always_comb begin
		cmd_in.addr  = table_index;
		cmd_in.value = table_value;
		cmd_in.node  = start_node;
		cmd_in.kind  = CMD_WALK;
		keep         = 1'b0;
		case (operation)
			OP_ROW: begin
				cmd_in.kind = CMD_ROW;
				keep        = idx32 < ROWS32;
			end
			OP_NBR: begin
				cmd_in.kind = CMD_NBR;
				keep        = idx32 < EDGES32;
			end
			OP_WALK: begin
				keep = 1'b1;
			end
			default: keep = 1'b0;
		endcase
	end

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= keep;
		end else if (push_ready) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1 <= cmd_in;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/bgrw_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgrw_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module bgrw_queue (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push_valid,
	output logic            push_ready,
	input  bgrw_pkg::cmd_t  push_cmd,
	output logic            pop_valid,
	input  wire logic       pop_ready,
	output bgrw_pkg::cmd_t  pop_cmd
);
	import bgrw_pkg::*;

	cmd_t       entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid  = count_q != 2'd0;
	assign pop_cmd    = entry_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wptr_q <= !wptr_q;
			if (pop) rptr_q <= !rptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wptr_q] <= push_cmd;
	end

endmodule
`default_nettype wire

[hw/rtl/bgrw_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bgrw_back
// Walk engine: graph stores, xorshift generator, bit-serial remainder unit,
// rejection sampler with adjacency scan, and the result register.
// ----------------------------------------------------------------------------
module bgrw_back #(
	parameter int MAX_NODES = bgrw_pkg::DEF_MAX_NODES,
	parameter int MAX_EDGES = bgrw_pkg::DEF_MAX_EDGES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  bgrw_pkg::cfg_t    cfg,
	input  wire logic         seed_load,
	input  wire logic [31:0]  seed,
	input  wire logic         pop_valid,
	output logic              pop_ready,
	input  bgrw_pkg::cmd_t    pop_cmd,
	output logic              out_valid,
	input  wire logic         out_ready,
	output logic [9:0]        visited_node,
	output logic [5:0]        step_number,
	output logic              last_of_walk
);
	import bgrw_pkg::*;

	localparam int RA_W = $clog2(MAX_NODES + 1);
	localparam int EA_W = $clog2(MAX_EDGES);
	localparam logic [31:0] NODES32 = 32'(MAX_NODES);
	localparam logic [31:0] EDGES32 = 32'(MAX_EDGES);

	typedef enum logic [3:0] {
		ST_IDLE, ST_EMIT, ST_DRAW, ST_LO, ST_HI, ST_DIV, ST_SLOT, ST_NRD,
		ST_CAND, ST_ALO, ST_AHI, ST_SCAN, ST_SCMP, ST_JUDGE
	} state_t;

	logic [13:0] row_mem [MAX_NODES + 1];
	logic [9:0]  nbr_mem [MAX_EDGES];
	logic [13:0] row_rd_q;
	logic [9:0]  nbr_rd_q;
	logic [RA_W-1:0] row_ra;
	logic [EA_W-1:0] nbr_ra;
	logic        row_we;
	logic        nbr_we;
	logic [31:0] addr32;

	state_t      state_q;
	logic [31:0] rng_q;
	logic [31:0] draw;
	logic [31:0] r_q;
	logic [5:0]  steps_q;
	logic [5:0]  k_q;
	logic        uniform_q;
	logic [9:0]  prev_q;
	logic [9:0]  prev2_q;
	logic [9:0]  cand_q;
	logic [13:0] lo_q;
	logic [13:0] hi_q;
	logic [13:0] div_q;
	logic [13:0] rem_q;
	logic [31:0] dvd_q;
	logic [4:0]  cnt_q;
	logic [13:0] scan_q;
	logic [15:0] frac_q;
	logic [16:0] thr_q;
	logic [7:0]  tries_q;
	logic        out_valid_q;
	logic [9:0]  out_node_q;
	logic [5:0]  out_step_q;
	logic        out_last_q;

	logic [14:0] div_t;
	logic [13:0] rem_n;
	logic [14:0] slot;
	logic        prev_out;
	logic        prev2_out;
	logic        out_free;
	logic [31:0] prev_p1;
	logic [31:0] prev2_p1;
	logic [31:0] slot32;
	logic [31:0] scan32;
	logic [5:0]  steps_in;

	assign draw      = next_draw(rng_q);
	assign addr32    = 32'(pop_cmd.addr);
	assign prev_p1   = 32'(prev_q) + 32'd1;
	assign prev2_p1  = 32'(prev2_q) + 32'd1;
	assign prev_out  = 32'(prev_q) >= NODES32;
	assign prev2_out = 32'(prev2_q) >= NODES32;
	assign div_t     = {rem_q, dvd_q[31]};
	assign rem_n     = (div_t >= {1'b0, div_q}) ? 14'(div_t - {1'b0, div_q}) : div_t[13:0];
	assign slot      = 15'(lo_q) + 15'(rem_q);
	assign slot32    = 32'(slot);
	assign scan32    = 32'(scan_q);
	assign out_free  = !out_valid_q || out_ready;
	assign steps_in  = (cfg.step_limit > MAX_WALK) ? MAX_WALK : cfg.step_limit;
	assign pop_ready = state_q == ST_IDLE;

	assign out_valid    = out_valid_q;
	assign visited_node = out_node_q;
	assign step_number  = out_step_q;
	assign last_of_walk = out_last_q;

	always_comb begin
		row_ra = RA_W'(32'(prev_q));
		case (state_q)
			ST_DRAW: row_ra = RA_W'(32'(prev_q));
			ST_LO:   row_ra = prev_p1[RA_W-1:0];
			ST_CAND: row_ra = RA_W'(32'(prev2_q));
			ST_ALO:  row_ra = prev2_p1[RA_W-1:0];
			default: row_ra = RA_W'(32'(prev_q));
		endcase
		nbr_ra = (state_q == ST_SLOT) ? slot32[EA_W-1:0] : scan32[EA_W-1:0];
		row_we = pop_valid && pop_ready && pop_cmd.kind == CMD_ROW;
		nbr_we = pop_valid && pop_ready && pop_cmd.kind == CMD_NBR;
	end

	always_ff @(posedge clk) begin
		if (row_we) row_mem[addr32[RA_W-1:0]] <= pop_cmd.value;
		row_rd_q <= row_mem[row_ra];
	end

	always_ff @(posedge clk) begin
		if (nbr_we) nbr_mem[addr32[EA_W-1:0]] <= pop_cmd.value[9:0];
		nbr_rd_q <= nbr_mem[nbr_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rng_q       <= 32'd1;
			out_valid_q <= 1'b0;
			steps_q     <= 6'd0;
			k_q         <= 6'd0;
			tries_q     <= 8'd0;
		end else begin
			if (out_ready && state_q != ST_EMIT) out_valid_q <= 1'b0;
			if (seed_load && state_q == ST_IDLE) rng_q <= seed;
			case (state_q)
				ST_IDLE: begin
					if (pop_valid && pop_cmd.kind == CMD_WALK) begin
						steps_q   <= steps_in;
						uniform_q <= cfg.return_accept >= FULL_ACCEPT &&
							cfg.common_accept >= FULL_ACCEPT &&
							cfg.far_accept >= FULL_ACCEPT;
						k_q       <= 6'd0;
						prev_q    <= pop_cmd.node;
						prev2_q   <= pop_cmd.node;
						state_q   <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_node_q  <= prev_q;
						out_step_q  <= k_q;
						out_last_q  <= k_q == steps_q;
						if (k_q == steps_q) begin
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + 6'd1;
							tries_q <= 8'd0;
							state_q <= ST_DRAW;
						end
					end
				end
				ST_DRAW: begin
					rng_q <= draw;
					r_q   <= draw;
					if (prev_out) begin
						cand_q  <= prev_q;
						state_q <= ST_CAND;
					end else begin
						state_q <= ST_LO;
					end
				end
				ST_LO: begin
					lo_q    <= row_rd_q;
					state_q <= ST_HI;
				end
				ST_HI: begin
					if (row_rd_q <= lo_q) begin
						cand_q  <= prev_q;
						state_q <= ST_CAND;
					end else begin
						div_q   <= row_rd_q - lo_q;
						rem_q   <= 14'd0;
						dvd_q   <= r_q;
						cnt_q   <= 5'd0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_n;
					dvd_q <= {dvd_q[30:0], 1'b0};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) state_q <= ST_SLOT;
				end
				ST_SLOT: begin
					if (slot >= 15'(cfg.edge_count) || slot32 >= EDGES32) begin
						cand_q  <= prev_q;
						state_q <= ST_CAND;
					end else begin
						state_q <= ST_NRD;
					end
				end
				ST_NRD: begin
					cand_q  <= nbr_rd_q;
					state_q <= ST_CAND;
				end
				ST_CAND: begin
					if (uniform_q || k_q == 6'd1) begin
						prev2_q <= prev_q;
						prev_q  <= cand_q;
						state_q <= ST_EMIT;
					end else begin
						rng_q  <= draw;
						frac_q <= draw[31:16];
						if (cand_q == prev2_q) begin
							thr_q   <= cfg.return_accept;
							state_q <= ST_JUDGE;
						end else if (prev2_out) begin
							thr_q   <= cfg.far_accept;
							state_q <= ST_JUDGE;
						end else begin
							state_q <= ST_ALO;
						end
					end
				end
				ST_ALO: begin
					lo_q    <= row_rd_q;
					state_q <= ST_AHI;
				end
				ST_AHI: begin
					hi_q    <= row_rd_q;
					scan_q  <= lo_q;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (scan_q < hi_q && scan_q < cfg.edge_count && scan32 < EDGES32) begin
						state_q <= ST_SCMP;
					end else begin
						thr_q   <= cfg.far_accept;
						state_q <= ST_JUDGE;
					end
				end
				ST_SCMP: begin
					if (nbr_rd_q == cand_q) begin
						thr_q   <= cfg.common_accept;
						state_q <= ST_JUDGE;
					end else begin
						scan_q  <= scan_q + 14'd1;
						state_q <= ST_SCAN;
					end
				end
				ST_JUDGE: begin
					if ({1'b0, frac_q} < thr_q) begin
						prev2_q <= prev_q;
						prev_q  <= cand_q;
						state_q <= ST_EMIT;
					end else if (tries_q == TRY_LAST) begin
						prev2_q <= prev_q;
						state_q <= ST_EMIT;
					end else begin
						tries_q <= tries_q + 8'd1;
						state_q <= ST_DRAW;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_step_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_step_q <= steps_q)
		else $error("result step beyond walk length");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_last_q == (out_step_q == steps_q)))
		else $error("last flag does not match final step");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> rem_q < div_q)
		else $error("remainder not below divisor");

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && out_free |=> out_valid_q && out_step_q == $past(k_q))
		else $error("emitted beat lost or out of order");

endmodule
`default_nettype wire

[tb/biased_graph_random_walk_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// biased_graph_random_walk_core_tb
// Loads a small CSR graph, then drives table writes and walk requests through
// several threshold, seed, length and edge-count settings. A scoreboard
// predicts every visited node and checks each output beat in order.
// ----------------------------------------------------------------------------
module biased_graph_random_walk_core_tb;
	import bgrw_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam logic [2:0] CFG_SPARE_LO = 3'd6;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [9:0] node;
		logic [5:0] step;
		logic       last;
	} visit_t;

	class walk_scoreboard;
		logic [13:0] row_ptr [0:1024];
		logic [9:0]  nbr [0:8191];
		bit [31:0] rng;
		bit [5:0]  walk_len;
		bit [16:0] ret_thr, com_thr, far_thr;
		bit [13:0] edges;
		visit_t visit_q[$];
		int errors, results, walks;

		function new();
			foreach (row_ptr[i]) row_ptr[i] = '0;
			foreach (nbr[i]) nbr[i] = '0;
			rng = 32'd1;
			walk_len = 6'd8;
			ret_thr = FULL_ACCEPT;
			com_thr = FULL_ACCEPT;
			far_thr = FULL_ACCEPT;
			edges = '0;
		endfunction

		function bit [31:0] advance_rng();
			rng = rng ^ (rng << 13);
			rng = rng ^ (rng >> 17);
			rng = rng ^ (rng << 5);
			return rng;
		endfunction

		function int unsigned sample_next(int unsigned node);
			bit [31:0] r;
			int unsigned lo, hi, slot;
			r = advance_rng();
			if (node >= 1024)
				return node;
			lo = row_ptr[node];
			hi = row_ptr[node + 1];
			if (hi <= lo)
				return node;
			slot = lo + r % (hi - lo);
			if (slot >= edges || slot >= 8192)
				return node;
			return nbr[slot];
		endfunction

		function bit is_linked(int unsigned cand, int unsigned origin);
			int unsigned lo, hi;
			if (origin >= 1024)
				return 1'b0;
			lo = row_ptr[origin];
			hi = row_ptr[origin + 1];
			for (int unsigned i = lo; i < hi && i < edges && i < 8192; i++)
				if (nbr[i] == cand)
					return 1'b1;
			return 1'b0;
		endfunction

		function void configure(logic [2:0] idx, logic [31:0] data);
			case (idx)
				CFG_WALK_LENGTH: walk_len = data[5:0];
				CFG_RETURN_ACCEPT: ret_thr = data[16:0];
				CFG_COMMON_ACCEPT: com_thr = data[16:0];
				CFG_FAR_ACCEPT: far_thr = data[16:0];
				CFG_RNG_SEED: rng = data;
				CFG_EDGE_COUNT: edges = data[13:0];
				default: ;
			endcase
		endfunction

		function void note(logic [1:0] op, logic [12:0] idx, logic [13:0] val,
				logic [9:0] start);
			int unsigned steps, prev, prev2, nxt, cand, thr;
			bit uniform;
			visit_t v;
			if (op == OP_ROW) begin
				if (idx <= 1024)
					row_ptr[idx] = val;
				return;
			end
			if (op == OP_NBR) begin
				nbr[idx] = val[9:0];
				return;
			end
			if (op != OP_WALK)
				return;
			walks++;
			steps = (walk_len > MAX_WALK) ? MAX_WALK : walk_len;
			uniform = ret_thr >= FULL_ACCEPT && com_thr >= FULL_ACCEPT &&
				far_thr >= FULL_ACCEPT;
			v.node = start;
			v.step = '0;
			v.last = (steps == 0);
			visit_q.push_back(v);
			prev = start;
			prev2 = start;
			for (int unsigned k = 1; k <= steps; k++) begin
				if (uniform || k == 1) begin
					nxt = sample_next(prev);
				end else begin
					nxt = prev;
					for (int t = 0; t < 256; t++) begin
						cand = sample_next(prev);
						if (cand == prev2)
							thr = ret_thr;
						else if (is_linked(cand, prev2))
							thr = com_thr;
						else
							thr = far_thr;
						if ((advance_rng() >> 16) < thr) begin
							nxt = cand;
							break;
						end
					end
				end
				nxt &= 32'h3FF;
				prev2 = prev;
				prev = nxt;
				v.node = 10'(nxt);
				v.step = 6'(k);
				v.last = (k == steps);
				visit_q.push_back(v);
			end
		endfunction

		function void check(logic [9:0] node, logic [5:0] step, logic last);
			visit_t v;
			results++;
			if (visit_q.size() == 0) begin
				$error("unexpected beat: visited_node %0d step_number %0d", node, step);
				errors++;
				return;
			end
			v = visit_q.pop_front();
			if (node !== v.node) begin
				$error("visited_node expected %0d actual %0d", v.node, node);
				errors++;
			end
			if (step !== v.step) begin
				$error("step_number expected %0d actual %0d", v.step, step);
				errors++;
			end
			if (last !== v.last) begin
				$error("last_of_walk expected %0d actual %0d", v.last, last);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  operation;
	logic [12:0] table_index;
	logic [13:0] table_value;
	logic [9:0]  start_node;
	logic        out_valid;
	logic        out_ready;
	logic [9:0]  visited_node;
	logic [5:0]  step_number;
	logic        last_of_walk;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	walk_scoreboard walk_sb;
	bit quiet;
	bit hold_req;
	int cfg_writes;

	biased_graph_random_walk_core uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .table_index(table_index),
		.table_value(table_value), .start_node(start_node),
		.out_valid(out_valid), .out_ready(out_ready),
		.visited_node(visited_node), .step_number(step_number),
		.last_of_walk(last_of_walk),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned graph_node();
		int unsigned k;
		k = $urandom_range(0, 16);
		return (k == 16) ? 1023 : k;
	endfunction

	task automatic send_beat(logic [1:0] op, logic [12:0] idx, logic [13:0] val,
			logic [9:0] node);
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 8);
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		operation = op;
		table_index = idx;
		table_value = val;
		start_node = node;
		do @(posedge clk); while (!in_ready);
		walk_sb.note(op, idx, val, node);
		@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		walk_sb.configure(idx, data);
		cfg_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (walk_sb.visit_q.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_mode(int wl, int rt, int ct, int ft, logic [31:0] seed, int ec);
		drain();
		write_reg(CFG_WALK_LENGTH, wl);
		write_reg(CFG_RETURN_ACCEPT, rt);
		write_reg(CFG_COMMON_ACCEPT, ct);
		write_reg(CFG_FAR_ACCEPT, ft);
		write_reg(CFG_RNG_SEED, seed);
		write_reg(CFG_EDGE_COUNT, ec);
	endtask

	task automatic random_item(bit walks_ok);
		int unsigned sel, k;
		logic [1:0]  op;
		logic [12:0] idx;
		logic [13:0] val;
		sel = $urandom_range(0, 99);
		idx = 13'($urandom);
		val = 14'($urandom_range(0, 8192));
		if (walks_ok && sel < 60) begin
			op = OP_WALK;
		end else if (sel < 75) begin
			op = OP_ROW;
			if ($urandom_range(0, 3) != 0) begin
				k = $urandom_range(0, 18);
				idx = 13'((k < 17) ? k : ((k == 17) ? 1023 : 1024));
				val = 14'($urandom_range(0, 64));
			end else begin
				idx = 13'($urandom_range(1025, 8191));
			end
		end else if (sel < 92) begin
			op = OP_NBR;
			if ($urandom_range(0, 2) != 0) begin
				idx = 13'($urandom_range(0, 63));
				val = 14'(($urandom_range(0, 7) << 10) | graph_node());
				if ($urandom_range(0, 15) == 0)
					val = 14'd8192;
			end else begin
				idx = 13'($urandom_range(64, 8191));
			end
		end else begin
			op = OP_SPARE;
		end
		send_beat(op, idx, val, 10'(graph_node()));
	endtask

	task automatic run_items(int count, int walk_cap);
		int started;
		started = walk_sb.walks;
		repeat (count) random_item(walk_sb.walks - started < walk_cap);
	endtask

	// receiver
	initial begin
		int stall;
		out_ready = 1'b0;
		stall = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (stall > 0) begin
				stall--;
				out_ready = 1'b0;
			end else if (!quiet && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 8) - 1;
				out_ready = 1'b0;
			end else begin
				out_ready = 1'b1;
			end
		end
	end

	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			walk_sb.check(visited_node, step_number, last_of_walk);

	// watchdog
	initial begin
		int idle;
		idle = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				idle = 0;
			else
				idle++;
			if (idle >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		walk_sb = new();
		quiet = 1'b0;
		hold_req = 1'b0;
		cfg_writes = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = OP_ROW;
		table_index = '0;
		table_value = '0;
		start_node = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// graph: nodes 0..15 with four neighbors each, node 1023 shares the last row
		for (int n = 0; n <= 16; n++)
			send_beat(OP_ROW, 13'(n), 14'(4 * n), '0);
		send_beat(OP_ROW, 13'd1023, 14'd60, '0);
		send_beat(OP_ROW, 13'd1024, 14'd64, '0);
		for (int s = 0; s < 64; s++)
			send_beat(OP_NBR, 13'(s), 14'(graph_node()), '0);

		// reset settings, edge count zero: every walk stays put
		send_beat(OP_WALK, '0, '0, 10'd0);
		send_beat(OP_WALK, 13'h1FFF, 14'h3FFF, 10'd1023);
		set_mode(8, FULL_ACCEPT, FULL_ACCEPT, FULL_ACCEPT, 32'h1234_5678, 64);
		write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_reg(CFG_SPARE_HI, 32'h0);
		send_beat(OP_WALK, '0, '0, 10'd0);
		send_beat(OP_WALK, '0, '0, 10'd1023);
		send_beat(OP_WALK, '0, '0, 10'd15);
		send_beat(OP_SPARE, 13'h1FFF, 14'd8192, 10'd1023);
		send_beat(OP_ROW, 13'h1FFF, 14'd8192, 10'd0);
		send_beat(OP_NBR, 13'h1FFF, 14'd8191, 10'd0);
		send_beat(OP_WALK, '0, '0, 10'd7);

		// receiver holds off while walks pile up
		hold_req = 1'b1;
		run_items(40, 1000);

		set_mode(63, 16384, 32768, 49152, $urandom | 1, 64);
		run_items(45, 1000);
		set_mode(1, 17'h1FFFF, 17'h1FFFF, 17'h10001, $urandom, 8192);
		run_items(40, 1000);
		set_mode(0, 20000, FULL_ACCEPT, FULL_ACCEPT, 32'hFFFF_FFFF, 64);
		run_items(25, 1000);
		set_mode(2, 0, 0, 0, $urandom | 1, 64);
		run_items(12, 3);
		set_mode(5, FULL_ACCEPT, 0, 30000, 32'h0, 32);
		run_items(30, 1000);
		set_mode(6, 60000, 40000, 20000, $urandom | 1, 0);
		run_items(30, 1000);
		set_mode(12, 50000, FULL_ACCEPT, 45000, $urandom | 1, 64);
		quiet = 1'b1;
		run_items(40, 1000);

		drain();
		$display("covered %0d walks and %0d visited-node beats over %0d register writes",
			walk_sb.walks, walk_sb.results, cfg_writes);
		if (walk_sb.visit_q.size() != 0) begin
			$error("%0d expected beats never arrived", walk_sb.visit_q.size());
			walk_sb.errors++;
		end
		if (walk_sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

[biased_graph_random_walk_core.f]
hw/rtl/bgrw_pkg.sv
hw/rtl/bgrw_front.sv
hw/rtl/bgrw_queue.sv
hw/rtl/bgrw_back.sv
hw/rtl/biased_graph_random_walk_core.sv
tb/biased_graph_random_walk_core_tb.sv
